// File: src/srp_pkg.sv
// Shared constants for the shelf rectangle packer.
package srp_pkg;

   localparam int FIELD_W = 12;

   // request kinds
   localparam logic KIND_PLACE = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

endpackage

// File: src/srp_ifs.sv
// Request and response channel interfaces of the shelf rectangle packer.
interface srp_req_if;
   import srp_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [FIELD_W-1:0]   rect_width;
   logic [FIELD_W-1:0]   rect_height;

   modport source (output valid, output kind, output rect_width, output rect_height,
                   input ready);
   modport sink   (input valid, input kind, input rect_width, input rect_height,
                   output ready);
endinterface

interface srp_rsp_if;
   import srp_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 placed;
   logic [FIELD_W-1:0]   offset_left;
   logic [FIELD_W-1:0]   offset_top;
   logic [FIELD_W-1:0]   draw_left;
   logic [FIELD_W-1:0]   draw_top;
   logic [FIELD_W-1:0]   draw_width;
   logic [FIELD_W-1:0]   draw_height;

   modport source (output valid, output placed, output offset_left, output offset_top,
                   output draw_left, output draw_top, output draw_width,
                   output draw_height, input ready);
   modport sink   (input valid, input placed, input offset_left, input offset_top,
                   input draw_left, input draw_top, input draw_width,
                   input draw_height, output ready);
endinterface

// File: src/shelf_rectangle_packer.sv
// Sequence: a clear request goes straight from idle to the done state; a place request
// reads shelf 0, scans the open shelves in order until one fits, else tries to open a
// new shelf in the append state, then answers from the done state. The scan checks one
// shelf a cycle through the single read port of the shelf memory.
// ready only while the sequencer is idle; a new request waits until the last response is registered.
// Reset: synchronous, clears the shelf count; the shelf memory holds no reset value.
module shelf_rectangle_packer #(
   parameter int ATLAS_SIZE  = 2048,
   parameter int MAX_SHELVES = 64,
   parameter int SPACING     = 1
) (
   input logic        clock,
   input logic        reset,
   srp_req_if.sink    req_ch,
   srp_rsp_if.source  rsp_ch
);
   import srp_pkg::*;

   localparam int AW   = $clog2(ATLAS_SIZE + 1);
   localparam int IW   = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
   localparam int CNTW = $clog2(MAX_SHELVES + 1);
   localparam int CW   = ((AW > FIELD_W) ? AW : FIELD_W) + 1;

   localparam logic [CW-1:0]      ATLAS_C = CW'(ATLAS_SIZE);
   localparam logic [CNTW-1:0]    MAX_C   = CNTW'(MAX_SHELVES);
   localparam logic [FIELD_W-1:0] SP_C    = FIELD_W'(SPACING);
   localparam logic [FIELD_W-1:0] SP2_C   = FIELD_W'(2 * SPACING);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_APPEND = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   typedef struct packed {
      logic [FIELD_W-1:0] height;
      logic [AW-1:0]      used;
   } shelf_type;

   state_type          state_ff, state_in;
   logic [CNTW-1:0]    count_ff, count_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      top_ff, top_in;
   logic               kind_ff, kind_in;
   logic [FIELD_W-1:0] width_ff, width_in;
   logic [FIELD_W-1:0] height_ff, height_in;
   logic               res_placed_ff, res_placed_in;
   logic [FIELD_W-1:0] res_left_ff, res_left_in;
   logic [FIELD_W-1:0] res_top_ff, res_top_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_placed_ff, rsp_placed_in;
   logic [FIELD_W-1:0] rsp_offset_left_ff, rsp_offset_left_in;
   logic [FIELD_W-1:0] rsp_offset_top_ff, rsp_offset_top_in;
   logic [FIELD_W-1:0] rsp_draw_left_ff, rsp_draw_left_in;
   logic [FIELD_W-1:0] rsp_draw_top_ff, rsp_draw_top_in;
   logic [FIELD_W-1:0] rsp_draw_width_ff, rsp_draw_width_in;
   logic [FIELD_W-1:0] rsp_draw_height_ff, rsp_draw_height_in;

   shelf_type          shelf_mem [MAX_SHELVES];
   shelf_type          rd_data_ff;
   logic               mem_we, mem_re;
   logic [IW-1:0]      mem_waddr, mem_raddr;
   shelf_type          mem_wdata;

   logic [CW-1:0]      sum_used;
   logic [CW-1:0]      top_next;
   logic [CW-1:0]      app_bottom;
   logic               fit;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         shelf_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= shelf_mem[mem_raddr];
      end
   end

   assign sum_used   = CW'(rd_data_ff.used) + CW'(width_ff);
   assign top_next   = CW'(top_ff) + CW'(rd_data_ff.height);
   assign app_bottom = CW'(top_ff) + CW'(height_ff);
   assign fit        = (rd_data_ff.height >= height_ff) && (sum_used <= ATLAS_C);

   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      idx_in             = idx_ff;
      top_in             = top_ff;
      kind_in            = kind_ff;
      width_in           = width_ff;
      height_in          = height_ff;
      res_placed_in      = res_placed_ff;
      res_left_in        = res_left_ff;
      res_top_in         = res_top_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_placed_in      = rsp_placed_ff;
      rsp_offset_left_in = rsp_offset_left_ff;
      rsp_offset_top_in  = rsp_offset_top_ff;
      rsp_draw_left_in   = rsp_draw_left_ff;
      rsp_draw_top_in    = rsp_draw_top_ff;
      rsp_draw_width_in  = rsp_draw_width_ff;
      rsp_draw_height_in = rsp_draw_height_ff;
      mem_we             = 1'b0;
      mem_re             = 1'b0;
      mem_waddr          = idx_ff;
      mem_raddr          = idx_ff;
      mem_wdata          = '0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               kind_in       = req_ch.kind;
               width_in      = req_ch.rect_width;
               height_in     = req_ch.rect_height;
               idx_in        = '0;
               top_in        = '0;
               res_placed_in = 1'b0;
               res_left_in   = '0;
               res_top_in    = '0;
               if (req_ch.kind == KIND_CLEAR) begin
                  count_in = '0;
                  state_in = ST_DONE;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = '0;
                  state_in  = (count_ff == '0) ? ST_APPEND : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // rd_data_ff holds the shelf at idx_ff
            if (fit) begin
               mem_we        = 1'b1;
               mem_waddr     = idx_ff;
               mem_wdata     = '{height: rd_data_ff.height, used: sum_used[AW-1:0]};
               res_placed_in = 1'b1;
               res_left_in   = FIELD_W'(rd_data_ff.used);
               res_top_in    = FIELD_W'(top_ff);
               state_in      = ST_DONE;
            end else begin
               top_in = top_next[AW-1:0];
               if ((CNTW'(idx_ff) + 1'b1) == count_ff) begin
                  state_in = ST_APPEND;
               end else begin
                  idx_in    = idx_ff + 1'b1;
                  mem_re    = 1'b1;
                  mem_raddr = idx_ff + 1'b1;
               end
            end
         end
         ST_APPEND: begin
            if ((count_ff < MAX_C) && (app_bottom <= ATLAS_C) &&
                (CW'(width_ff) <= ATLAS_C)) begin
               mem_we        = 1'b1;
               mem_waddr     = count_ff[IW-1:0];
               mem_wdata     = '{height: height_ff, used: AW'(width_ff)};
               count_in      = count_ff + 1'b1;
               res_placed_in = 1'b1;
               res_left_in   = '0;
               res_top_in    = FIELD_W'(top_ff);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in       = 1'b1;
               rsp_placed_in      = res_placed_ff;
               rsp_offset_left_in = res_left_ff;
               rsp_offset_top_in  = res_top_ff;
               rsp_draw_left_in   = '0;
               rsp_draw_top_in    = '0;
               rsp_draw_width_in  = '0;
               rsp_draw_height_in = '0;
               if (res_placed_ff) begin
                  rsp_draw_left_in   = res_left_ff + SP_C;
                  rsp_draw_top_in    = res_top_ff + SP_C;
                  rsp_draw_width_in  = (width_ff > SP2_C) ? (width_ff - SP2_C) : '0;
                  rsp_draw_height_in = (height_ff > SP2_C) ? (height_ff - SP2_C) : '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff             <= idx_in;
      top_ff             <= top_in;
      kind_ff            <= kind_in;
      width_ff           <= width_in;
      height_ff          <= height_in;
      res_placed_ff      <= res_placed_in;
      res_left_ff        <= res_left_in;
      res_top_ff         <= res_top_in;
      rsp_placed_ff      <= rsp_placed_in;
      rsp_offset_left_ff <= rsp_offset_left_in;
      rsp_offset_top_ff  <= rsp_offset_top_in;
      rsp_draw_left_ff   <= rsp_draw_left_in;
      rsp_draw_top_ff    <= rsp_draw_top_in;
      rsp_draw_width_ff  <= rsp_draw_width_in;
      rsp_draw_height_ff <= rsp_draw_height_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.placed      = rsp_placed_ff;
   assign rsp_ch.offset_left = rsp_offset_left_ff;
   assign rsp_ch.offset_top  = rsp_offset_top_ff;
   assign rsp_ch.draw_left   = rsp_draw_left_ff;
   assign rsp_ch.draw_top    = rsp_draw_top_ff;
   assign rsp_ch.draw_width  = rsp_draw_width_ff;
   assign rsp_ch.draw_height = rsp_draw_height_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_C)
      else $error("shelf count beyond table size");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.kind == KIND_CLEAR) |=> (count_ff == '0))
      else $error("clear request left shelves open");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CNTW'(idx_ff) < count_ff))
      else $error("scan index past open shelves");

   a_draw_offset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ch.ready) && res_placed_ff)
         |=> (rsp_valid_ff && rsp_placed_ff && rsp_draw_left_ff == rsp_offset_left_ff + SP_C))
      else $error("draw left not offset by spacing");

   a_kind_place_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_APPEND) |-> (kind_ff == KIND_PLACE))
      else $error("clear request entered the shelf scan");

endmodule

// File: dv/srp_placement_checker.sv
// Shelf packer checker: tracks its own shelf table and compares every response in order.
`timescale 1ns / 1ps
module srp_placement_checker #(
   parameter int ATLAS_SIZE  = 2048,
   parameter int MAX_SHELVES = 64,
   parameter int SPACING     = 1
) (
   input  logic        clock,
   input  logic        reset,
   srp_req_if          req_mon,
   srp_rsp_if          rsp_mon,
   output int unsigned responses_owed,
   output int unsigned fail_count
);
   import srp_pkg::*;

   typedef logic [FIELD_W-1:0] field_type;
   typedef struct packed {
      logic      placed;
      field_type offset_left;
      field_type offset_top;
      field_type draw_left;
      field_type draw_top;
      field_type draw_width;
      field_type draw_height;
   } placement_type;

   int unsigned   shelf_h    [MAX_SHELVES];
   int unsigned   shelf_fill [MAX_SHELVES];
   int unsigned   open_shelves;
   placement_type owed_q [$];
   int unsigned   bad_count;

   function automatic int unsigned trim(int unsigned size);
      return (size > 2 * SPACING) ? size - 2 * SPACING : 0;
   endfunction

   // first-fit scan over the open shelves, else open one below the last
   function automatic placement_type place_rect(int unsigned w, int unsigned h);
      placement_type res;
      int unsigned   top;
      int unsigned   left;
      bit            found;
      res   = '0;
      top   = 0;
      left  = 0;
      found = 1'b0;
      for (int i = 0; i < open_shelves; i++) begin
         if (!found && shelf_h[i] >= h && shelf_fill[i] + w <= ATLAS_SIZE) begin
            left          = shelf_fill[i];
            shelf_fill[i] = left + w;
            found         = 1'b1;
         end else if (!found) begin
            top += shelf_h[i];
         end
      end
      if (!found && open_shelves < MAX_SHELVES && top + h <= ATLAS_SIZE &&
          w <= ATLAS_SIZE) begin
         shelf_h[open_shelves]    = h;
         shelf_fill[open_shelves] = w;
         open_shelves++;
         left  = 0;
         found = 1'b1;
      end
      if (found) begin
         res.placed      = 1'b1;
         res.offset_left = field_type'(left);
         res.offset_top  = field_type'(top);
         res.draw_left   = field_type'(left + SPACING);
         res.draw_top    = field_type'(top + SPACING);
         res.draw_width  = field_type'(trim(w));
         res.draw_height = field_type'(trim(h));
      end
      return res;
   endfunction

   function automatic string describe(placement_type p);
      return $sformatf("placed=%0d offset=(%0d,%0d) draw=(%0d,%0d %0dx%0d)",
                       p.placed, p.offset_left, p.offset_top, p.draw_left, p.draw_top,
                       p.draw_width, p.draw_height);
   endfunction

   always @(posedge clock) begin
      placement_type seen;
      placement_type want;
      if (reset) begin
         open_shelves = 0;
         owed_q.delete();
         bad_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.placed      = rsp_mon.placed;
            seen.offset_left = rsp_mon.offset_left;
            seen.offset_top  = rsp_mon.offset_top;
            seen.draw_left   = rsp_mon.draw_left;
            seen.draw_top    = rsp_mon.draw_top;
            seen.draw_width  = rsp_mon.draw_width;
            seen.draw_height = rsp_mon.draw_height;
            if (owed_q.size() == 0) begin
               bad_count++;
               if (bad_count <= 10)
                  $display("unexpected response: %s", describe(seen));
            end else begin
               want = owed_q.pop_front();
               if (seen !== want) begin
                  bad_count++;
                  if (bad_count <= 10)
                     $display("placement mismatch: expected %s, got %s",
                              describe(want), describe(seen));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.kind == KIND_CLEAR) begin
               open_shelves = 0;
               owed_q.push_back('0);
            end else begin
               owed_q.push_back(place_rect(req_mon.rect_width, req_mon.rect_height));
            end
         end
      end
      responses_owed <= owed_q.size();
      fail_count     <= bad_count;
   end

endmodule

// File: dv/shelf_rectangle_packer_test.sv
// Testbench top for the shelf rectangle packer: request stimulus, response stalls, verdict.
`timescale 1ns / 1ps
module shelf_rectangle_packer_test;
   import srp_pkg::*;

   localparam int ATLAS_SIZE   = 2048;
   localparam int MAX_SHELVES  = 64;
   localparam int SPACING      = 1;
   localparam int ITEM_TARGET  = 1250;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = MAX_SHELVES + 10;
   localparam int FIELD_MAX    = (1 << FIELD_W) - 1;

   typedef enum int {GLYPHS, STRIPS, TALL, MIXED, NOISE} episode_type;

   logic        clock;
   logic        reset;
   int unsigned responses_owed;
   int unsigned fail_count;
   int unsigned requests_sent = 0;
   int unsigned idle_cycles = 0;
   bit          no_idle = 1'b0;

   srp_req_if req_ch();
   srp_rsp_if rsp_ch();

   shelf_rectangle_packer #(
      .ATLAS_SIZE (ATLAS_SIZE),
      .MAX_SHELVES(MAX_SHELVES),
      .SPACING    (SPACING)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   srp_placement_checker #(
      .ATLAS_SIZE (ATLAS_SIZE),
      .MAX_SHELVES(MAX_SHELVES),
      .SPACING    (SPACING)
   ) placement_chk (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .responses_owed(responses_owed),
      .fail_count    (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned draw_gap();
      return no_idle ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic send_request(input logic kind, input int unsigned w, input int unsigned h);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= kind;
      req_ch.rect_width  <= w[FIELD_W-1:0];
      req_ch.rect_height <= h[FIELD_W-1:0];
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      requests_sent++;
   endtask

   // owed count is registered, so look only after a fresh edge
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (responses_owed != 0) @(posedge clock);
   endtask

   // response side: random stall after each accepted response
   initial begin
      int unsigned gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap();
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      episode_type profile;
      int unsigned burst;
      int unsigned roll;
      reset = 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.kind        <= KIND_PLACE;
      req_ch.rect_width  <= '0;
      req_ch.rect_height <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty rectangles, zero-height shelf, too wide, no vertical room, full rows
      send_request(KIND_PLACE, 0, 0);
      send_request(KIND_PLACE, ATLAS_SIZE, 0);
      send_request(KIND_PLACE, 1, 1);
      send_request(KIND_PLACE, ATLAS_SIZE + 1, 1);
      send_request(KIND_PLACE, FIELD_MAX, FIELD_MAX);
      send_request(KIND_PLACE, 1, ATLAS_SIZE);
      send_request(KIND_PLACE, 2, ATLAS_SIZE - 1);
      send_request(KIND_PLACE, ATLAS_SIZE - 2, ATLAS_SIZE - 1);
      send_request(KIND_PLACE, 1, 1);
      send_request(KIND_PLACE, 1, 2);
      send_request(KIND_PLACE, 5, 0);
      send_request(KIND_PLACE, 'hAAA, 'h555);
      send_request(KIND_PLACE, 'h555, 'hAAA);
      send_request(KIND_CLEAR, FIELD_MAX, FIELD_MAX);
      send_request(KIND_PLACE, ATLAS_SIZE, ATLAS_SIZE);
      send_request(KIND_PLACE, 0, 0);
      send_request(KIND_PLACE, 3, 3);
      send_request(KIND_CLEAR, 0, 0);
      drain_responses();

      while (requests_sent < ITEM_TARGET) begin
         no_idle <= ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) == 0)
            drain_responses();
         if ($urandom_range(0, 4) != 0)
            send_request(KIND_CLEAR, $urandom_range(0, FIELD_MAX),
                         $urandom_range(0, FIELD_MAX));
         profile = episode_type'($urandom_range(0, 4));
         case (profile)
            GLYPHS: burst = $urandom_range(20, 120);
            STRIPS: burst = $urandom_range(60, 90);
            TALL:   burst = $urandom_range(4, 20);
            MIXED:  burst = $urandom_range(10, 40);
            default: burst = $urandom_range(4, 16);
         endcase
         for (int n = 0; n < burst; n++) begin
            roll = $urandom_range(0, 31);
            if (roll == 0) begin
               send_request(KIND_CLEAR, $urandom_range(0, FIELD_MAX),
                            $urandom_range(0, FIELD_MAX));
            end else if (roll < 3 || profile == NOISE) begin
               send_request(($urandom_range(0, 7) == 0) ? KIND_CLEAR : KIND_PLACE,
                            $urandom_range(0, FIELD_MAX), $urandom_range(0, FIELD_MAX));
            end else begin
               case (profile)
                  GLYPHS:
                     send_request(KIND_PLACE, $urandom_range(0, 64), $urandom_range(0, 32));
                  STRIPS:
                     // near-full rows open many shelves; narrow ones fill the gaps deep down
                     if (roll < 10)
                        send_request(KIND_PLACE, $urandom_range(0, 8), $urandom_range(0, 40));
                     else
                        send_request(KIND_PLACE, $urandom_range(ATLAS_SIZE - 8, ATLAS_SIZE),
                                     $urandom_range(0, 40));
                  TALL:
                     send_request(KIND_PLACE, $urandom_range(0, ATLAS_SIZE),
                                  $urandom_range(100, ATLAS_SIZE));
                  default:
                     send_request(KIND_PLACE, $urandom_range(0, ATLAS_SIZE),
                                  $urandom_range(0, ATLAS_SIZE) >> $urandom_range(0, 6));
               endcase
            end
         end
      end

      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// File: files.f
src/srp_pkg.sv
src/srp_ifs.sv
src/shelf_rectangle_packer.sv
dv/srp_placement_checker.sv
dv/shelf_rectangle_packer_test.sv
